[hw/rtl/dlc_pkg.sv]
// ----------------------------------------------------------------------------
// dlc_pkg: shared definitions for the LBA to CHS request translator
// Sizes, task-file codes, register indexes and the pipeline stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package dlc_pkg;

  localparam int SECTOR_BYTES  = 512;
  localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
  localparam int MAX_TRANSFER  = 4 * 1024;
  localparam int MAX_READ      = 1 * 1024;

  // Sector count width: at least the 4-bit task-file field
  localparam int NSEC_RAW_W = $clog2(MAX_TRANSFER / SECTOR_BYTES + 1);
  localparam int NSEC_W     = (NSEC_RAW_W > 4) ? NSEC_RAW_W : 4;

  // Divider geometry: 32-bit dividend, 8-bit divisor, four bits a stage
  localparam int DIV_BITS   = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  localparam logic [7:0] CMD_READ_CODE  = 8'h20;
  localparam logic [7:0] CMD_WRITE_CODE = 8'h30;
  localparam logic [7:0] DH_FIXED_BITS  = 8'h20;

  // Configuration register indexes
  localparam logic [2:0] REG_DRIVE_ONLINE = 3'd0;
  localparam logic [2:0] REG_DRIVE_UNIT   = 3'd1;
  localparam logic [2:0] REG_SPT          = 3'd2;
  localparam logic [2:0] REG_HPC          = 3'd3;
  localparam logic [2:0] REG_PART_FIRST   = 3'd4;
  localparam logic [2:0] REG_PART_LIMIT   = 3'd5;

  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_ZERO     = 2'd1,
    OUT_PAST_END = 2'd2,
    OUT_OFFLINE  = 2'd3
  } outcome_t;

  typedef struct packed {
    outcome_t              outcome;
    logic                  cmd;
    logic [NSEC_W-1:0]     nsec;
    logic [7:0]            sec;
    logic [7:0]            rem;
    logic [DIV_BITS-1:0]   num;
  } stage_t;

endpackage

`default_nettype wire

[hw/rtl/dlc_div_stage.sv]
// ----------------------------------------------------------------------------
// dlc_div_stage: one registered slice of a restoring divider
// Retires DIV_STEPS quotient bits per stage, carrying the request along.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_div_stage import dlc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic       in_valid,
  input  wire stage_t     in_data,
  input  wire logic [7:0] divisor,
  output logic            out_valid,
  output stage_t          out_data
);

  stage_t data_next;

  // Shift in dividend bits, subtract where the partial remainder allows
  always_comb begin
    logic [7:0]          r;
    logic [DIV_BITS-1:0] n;
    logic [8:0]          t;
    logic                q;
    r = in_data.rem;
    n = in_data.num;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {r, n[DIV_BITS-1]};
      q = (t >= {1'b0, divisor});
      if (q) begin
        r = 8'(t - {1'b0, divisor});
      end else begin
        r = t[7:0];
      end
      n = {n[DIV_BITS-2:0], q};
    end
    data_next     = in_data;
    data_next.rem = r;
    data_next.num = n;
  end

  // Advance when the stage is free or its successor moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
    if (load) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/disk_lba_to_chs_request.sv]
// ----------------------------------------------------------------------------
// disk_lba_to_chs_request: byte request to ATA CHS task-file values
// Clamps and rounds the length, bounds it to the partition, splits the block.
// ----------------------------------------------------------------------------
// Pipeline: 18 register stages, the first loaded at the accepting edge.
// Throughput: one request per cycle unless out_ready stalls the output;
// two 8-stage dividers (by sectors per track, then by heads) retire four
// quotient bits in each stage.
// Each stage advances on its own, so bubbles close up under a stall.
// Reset clears all valid bits and loads the register defaults; no sweep.
`default_nettype none

module disk_lba_to_chs_request import dlc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [40:0] byte_offset,
  input  wire logic [30:0] byte_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       outcome,
  output logic [3:0]       sector_count,
  output logic [7:0]       sector_number,
  output logic [15:0]      cylinder,
  output logic [7:0]       drive_head,
  output logic [7:0]       command_code
);

  localparam int NSTG = 2 + 2 * DIV_STAGES;

  // Configuration registers
  logic        drive_online;
  logic        drive_unit;
  logic [7:0]  spt;
  logic [4:0]  hpc;
  logic [31:0] part_first;
  logic [31:0] part_limit;
  logic [7:0]  spt_eff;
  logic [7:0]  hpc_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_online <= 1'b0;
      drive_unit   <= 1'b0;
      spt          <= 8'd1;
      hpc          <= 5'd1;
      part_first   <= '0;
      part_limit   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DRIVE_ONLINE: drive_online <= cfg_data[0];
        REG_DRIVE_UNIT:   drive_unit   <= cfg_data[0];
        REG_SPT:          spt          <= cfg_data[7:0];
        REG_HPC:          hpc          <= cfg_data[4:0];
        REG_PART_FIRST:   part_first   <= cfg_data;
        REG_PART_LIMIT:   part_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Treat zero geometry as one
  assign spt_eff = (spt == 8'd0) ? 8'd1 : spt;
  assign hpc_eff = (hpc == 5'd0) ? 8'd1 : {3'b000, hpc};

  // Stage handshake: a stage loads when empty or when its successor moves
  logic [NSTG-1:0]         v;
  logic [NSTG-1:0]         mv;
  logic                    v_a;
  logic                    v_b;
  logic [2*DIV_STAGES-1:0] v_div;

  assign v = {v_div, v_b, v_a};

  always_comb begin
    mv[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      mv[i] = !v[i] || mv[i+1];
    end
  end

  assign in_ready = mv[0];

  // Stage A: block sum, clamped length in sectors, early status
  logic [32:0]       a_lblk;
  logic [NSEC_W-1:0] a_nsec;
  logic              a_cmd;
  outcome_t          a_outcome;
  logic [32:0]       lblk_next;
  logic [NSEC_W-1:0] nsec_next;
  outcome_t          a_outcome_next;

  always_comb begin
    logic [30:0] lc;
    logic [30:0] nsec_full;
    lc = (byte_length > 31'(MAX_TRANSFER)) ? 31'(MAX_TRANSFER) : byte_length;
    if (!command && (lc > 31'(MAX_READ))) begin
      lc = 31'(MAX_READ);
    end
    nsec_full = 31'(lc + 31'(SECTOR_BYTES - 1)) >> SECTOR_SHIFT;
    nsec_next = nsec_full[NSEC_W-1:0];
    lblk_next = {1'b0, byte_offset[40:SECTOR_SHIFT]} + {1'b0, part_first};
    if (!drive_online) begin
      a_outcome_next = OUT_OFFLINE;
    end else if (nsec_next == '0) begin
      a_outcome_next = OUT_ZERO;
    end else begin
      a_outcome_next = OUT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (mv[0]) begin
      v_a <= in_valid;
    end
    if (mv[0]) begin
      a_lblk    <= lblk_next;
      a_nsec    <= nsec_next;
      a_cmd     <= command;
      a_outcome <= a_outcome_next;
    end
  end

  // Stage B: partition bound and count trim
  stage_t b_data;
  stage_t b_next;

  always_comb begin
    logic [31:0] room;
    room               = part_limit - a_lblk[31:0];
    b_next.outcome     = a_outcome;
    b_next.cmd         = a_cmd;
    b_next.nsec        = a_nsec;
    b_next.sec         = '0;
    b_next.rem         = '0;
    b_next.num         = a_lblk[31:0];
    if (a_outcome == OUT_OK) begin
      if (a_lblk >= {1'b0, part_limit}) begin
        b_next.outcome = OUT_PAST_END;
      end else if (room < 32'(a_nsec)) begin
        b_next.nsec    = room[NSEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (mv[1]) begin
      v_b <= v[0];
    end
    if (mv[1]) begin
      b_data <= b_next;
    end
  end

  // Divider chain: block / spt, then quotient / hpc
  stage_t dd  [2*DIV_STAGES];
  stage_t din [2*DIV_STAGES];
  logic   dvin[2*DIV_STAGES];

  always_comb begin
    for (int i = 0; i < 2 * DIV_STAGES; i++) begin
      if (i == 0) begin
        din[i]  = b_data;
        dvin[i] = v[1];
      end else begin
        din[i]  = dd[i-1];
        dvin[i] = v[i+1];
        if (i == DIV_STAGES) begin
          din[i].sec = 8'(dd[i-1].rem + 8'd1);
          din[i].rem = '0;
        end
      end
    end
  end

  for (genvar g = 0; g < 2 * DIV_STAGES; g++) begin : g_div
    dlc_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .load      (mv[g+2]),
      .in_valid  (dvin[g]),
      .in_data   (din[g]),
      .divisor   ((g < DIV_STAGES) ? spt_eff : hpc_eff),
      .out_valid (v_div[g]),
      .out_data  (dd[g])
    );
  end

  // Drive the task-file values, zero on any error outcome
  stage_t fin;
  logic   ok;

  assign fin           = dd[2*DIV_STAGES-1];
  assign ok            = (fin.outcome == OUT_OK);
  assign out_valid     = v[NSTG-1];
  assign outcome       = fin.outcome;
  assign sector_count  = ok ? fin.nsec[3:0] : 4'd0;
  assign sector_number = ok ? fin.sec : 8'd0;
  assign cylinder      = ok ? fin.num[15:0] : 16'd0;
  assign drive_head    = ok ? (DH_FIXED_BITS | {3'b000, drive_unit, 4'b0000} |
                               {4'b0000, fin.rem[3:0]}) : 8'd0;
  assign command_code  = ok ? (fin.cmd ? CMD_WRITE_CODE : CMD_READ_CODE) : 8'd0;

  // An empty first stage always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> in_ready)
    else $error("first stage empty but request refused");

  // A request that passes the bounds keeps a non-zero count
  a_b_count: assert property (@(posedge clk) disable iff (rst)
    v[1] && (b_data.outcome == OUT_OK) |-> (b_data.nsec != '0))
    else $error("issued request with zero sectors");

  // Head remainder stays below the head count; sector number is non-zero
  a_head_rem: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> (fin.rem < hpc_eff) && (sector_number != 8'd0))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LBA to CHS request translator
// Drives read and write requests under several register settings, predicts
// each task-file result and compares it with the block's output in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import dlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        command;
    logic [40:0] byte_offset;
    logic [30:0] byte_length;
  } request_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [3:0]  sector_count;
    logic [7:0]  sector_number;
    logic [15:0] cylinder;
    logic [7:0]  drive_head;
    logic [7:0]  command_code;
  } taskfile_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [40:0] byte_offset = '0;
  logic [30:0] byte_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic [3:0] sector_count;
  logic [7:0] sector_number;
  logic [15:0] cylinder;
  logic [7:0] drive_head;
  logic [7:0] command_code;

  disk_lba_to_chs_request i_dut (.*);

  // Register copies used by the translation predictor
  logic        reg_online = 1'b0;
  logic        reg_unit = 1'b0;
  logic [7:0]  reg_spt = 8'd1;
  logic [4:0]  reg_hpc = 5'd1;
  logic [31:0] reg_first = '0;
  logic [31:0] reg_limit = '0;

  request_t  pending_requests[$];
  taskfile_t expected_taskfiles[$];
  int errors = 0;
  int results_seen = 0;
  int ok_seen = 0;
  longint cycles = 0;
  bit quiet_end = 0;
  bit hold_output = 0;
  int drive_gap = 0;
  int recv_gap = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic taskfile_t translate(request_t r);
    taskfile_t t;
    longint unsigned len, nsec, lblk, spt, hpc, head;
    t = '0;
    if (!reg_online) begin
      t.outcome = OUT_OFFLINE;
      return t;
    end
    len = r.byte_length;
    if (len > MAX_TRANSFER) len = MAX_TRANSFER;
    if (!r.command && len > MAX_READ) len = MAX_READ;
    nsec = (len + SECTOR_BYTES - 1) / SECTOR_BYTES;
    if (nsec == 0) begin
      t.outcome = OUT_ZERO;
      return t;
    end
    lblk = longint'(r.byte_offset / SECTOR_BYTES) + longint'(reg_first);
    if (lblk >= reg_limit) begin
      t.outcome = OUT_PAST_END;
      return t;
    end
    spt = (reg_spt == 0) ? 1 : reg_spt;
    hpc = (reg_hpc == 0) ? 1 : reg_hpc;
    head = (lblk / spt) % hpc;
    if (lblk + nsec > reg_limit) nsec = reg_limit - lblk;
    t.outcome = OUT_OK;
    t.sector_count = nsec[3:0];
    t.sector_number = 8'((lblk % spt) + 1);
    t.cylinder = 16'(lblk / (spt * hpc));
    t.drive_head = DH_FIXED_BITS | {3'b0, reg_unit, 4'b0} | {4'b0, head[3:0]};
    t.command_code = r.command ? CMD_WRITE_CODE : CMD_READ_CODE;
    return t;
  endfunction

  // Driver: offer queued requests, with random idle bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_taskfiles.push_back(translate({command, byte_offset, byte_length}));
      end
      if (!in_valid || in_ready) begin
        if (drive_gap > 0) begin
          drive_gap <= drive_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          {command, byte_offset, byte_length} <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (!quiet_end && $urandom_range(0, 15) == 0) drive_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      taskfile_t got, want;
      got = {outcome, sector_count, sector_number, cylinder, drive_head, command_code};
      results_seen++;
      if (expected_taskfiles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_taskfiles.pop_front();
        if (want.outcome == OUT_OK) ok_seen++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp oc=%0d n=%0d s=%0d c=%0d dh=%h cc=%h, got oc=%0d n=%0d s=%0d c=%0d dh=%h cc=%h",
                     want.outcome, want.sector_count, want.sector_number, want.cylinder,
                     want.drive_head, want.command_code, got.outcome, got.sector_count,
                     got.sector_number, got.cylinder, got.drive_head, got.command_code);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst || hold_output) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_end && $urandom_range(0, 12) == 0) recv_gap <= $urandom_range(1, 19);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DRIVE_ONLINE: reg_online = val[0];
      REG_DRIVE_UNIT:   reg_unit = val[0];
      REG_SPT:          reg_spt = val[7:0];
      REG_HPC:          reg_hpc = val[4:0];
      REG_PART_FIRST:   reg_first = val;
      REG_PART_LIMIT:   reg_limit = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0);
    do @(posedge clk); while (in_valid || expected_taskfiles.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic request_t rand_request(logic [31:0] span);
    request_t r;
    r.command = 1'($urandom_range(0, 1));
    r.byte_offset = 41'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0)
      r.byte_offset = 41'($urandom_range(0, span)) * SECTOR_BYTES + 41'($urandom_range(0, 511));
    case ($urandom_range(0, 4))
      0: r.byte_length = 31'($urandom);
      1: r.byte_length = '0;
      default: r.byte_length = 31'($urandom_range(0, 5000));
    endcase
    return r;
  endfunction

  initial begin
    logic [31:0] first, lim, span;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: offline at reset, then field extremes and special cases
    pending_requests.push_back({1'b0, 41'd0, 31'd512});
    pending_requests.push_back({1'b1, {41{1'b1}}, {31{1'b1}}});
    drain();
    write_reg(REG_DRIVE_ONLINE, 1);
    write_reg(REG_DRIVE_UNIT, 1);
    write_reg(REG_SPT, 0);
    write_reg(REG_HPC, 0);
    write_reg(REG_PART_FIRST, 32'hFFFF_FF00);
    write_reg(REG_PART_LIMIT, 32'hFFFF_FFFF);
    pending_requests.push_back({1'b0, 41'd0, 31'd0});
    pending_requests.push_back({1'b1, 41'd0, 31'd1});
    pending_requests.push_back({1'b0, 41'd0, 31'd4097});
    pending_requests.push_back({1'b1, 41'd0, {31{1'b1}}});
    pending_requests.push_back({1'b1, 41'd0, 31'd4096});
    pending_requests.push_back({1'b1, 41'(32'hFE) * 512, 31'd4096});
    pending_requests.push_back({1'b0, 41'(32'hFF) * 512, 31'd512});
    pending_requests.push_back({1'b0, {41{1'b1}}, 31'd100});
    pending_requests.push_back({1'b1, 41'h100 * 512 + 41'd511, 31'd513});
    drain();
    write_reg(REG_SPT, 255);
    write_reg(REG_HPC, 31);
    write_reg(REG_DRIVE_UNIT, 0);
    write_reg(REG_PART_FIRST, 0);
    write_reg(REG_PART_LIMIT, 32'hFFFF_FFFF);
    pending_requests.push_back({1'b0, 41'd1000 * 512, 31'd1024});
    pending_requests.push_back({1'b1, 41'd7904 * 512, 31'd2048});
    pending_requests.push_back({1'b1, 41'hFFFF_FFFE * 512, 31'd4096});
    drain();

    // Random phases over varied geometry and partitions
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DRIVE_ONLINE, (ph == 3) ? 0 : 1);
      write_reg(REG_DRIVE_UNIT, $urandom_range(0, 1));
      write_reg(REG_SPT, (ph == 0) ? 1 : (ph == 1) ? 255 : $urandom_range(0, 255));
      write_reg(REG_HPC, (ph == 0) ? 1 : (ph == 1) ? 16 : $urandom_range(0, 31));
      first = (ph == 2) ? 32'hFFFF_F000 : (ph == 4) ? 0 : $urandom;
      span = $urandom_range(16, 5000);
      lim = (ph == 2) ? 32'hFFFF_FFFF : first + span;
      if (lim < first) lim = 32'hFFFF_FFFF;
      write_reg(REG_PART_FIRST, first);
      write_reg(REG_PART_LIMIT, lim);
      if (ph == 7) quiet_end = 1;
      for (int k = 0; k < 200; k++) pending_requests.push_back(rand_request(span + 16));
      if (ph == 5) begin
        // Stall the output long enough for the pipeline to fill up
        hold_output = 1;
        repeat (300) @(posedge clk);
        hold_output = 0;
      end
      drain();
    end

    $display("covered %0d results, %0d issued commands, over eight register settings",
             results_seen, ok_seen);
    if (errors == 0 && expected_taskfiles.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
